>>> hw/rtl/pps_pkg.sv
`default_nettype none

package pps_pkg;

   localparam int MAX_JOBS_DEFAULT = 16;
   localparam int ARRIVAL_W        = 16;
   localparam int BURST_W          = 16;
   localparam int PRIORITY_W       = 8;
   localparam int RSP_INDEX_W      = 4;
   localparam int RSP_TIME_W       = 21;

   typedef struct packed {
      logic [ARRIVAL_W-1:0]  arrival_time;
      logic [BURST_W-1:0]    burst_time;
      logic [PRIORITY_W-1:0] job_priority;
      logic                  last_item;
   } req_type;

   typedef struct packed {
      logic [RSP_INDEX_W-1:0] job_index;
      logic [RSP_TIME_W-1:0]  finish_time;
      logic [RSP_TIME_W-1:0]  turnaround_time;
      logic [RSP_TIME_W-1:0]  waiting_time;
      logic                   excess_dropped;
      logic                   last_result;
   } rsp_type;

   // One row of the job table, apart from the finish time.
   typedef struct packed {
      logic [ARRIVAL_W-1:0]  arrival_time;
      logic [BURST_W-1:0]    burst_time;
      logic [PRIORITY_W-1:0] job_priority;
      logic [BURST_W-1:0]    remaining_time;
   } job_entry_type;

   typedef struct packed {
      logic                 found;
      logic                 pending;
      logic [ARRIVAL_W-1:0] next_arrival;
   } sel_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/preemptive_priority_scheduler.sv
`default_nettype none

// Preemptive priority scheduler. Jobs are loaded one request per cycle into a
// single-port-write job table; the request with last_item set closes the set
// and the block stalls its input while it schedules. Each scheduling event is
// one pass over the table through the memory read port for N stored jobs: the
// scan, scan-end, decide and apply states when the best ready job runs until
// it finishes or the next job arrives, or scan, scan-end and decide when an
// idle span is jumped to the next arrival. A set needs at most about 2N events.
// Results then leave in load order, one at a time (read, format, hand over),
// and loading resumes after the last one is taken. Jobs beyond MAX_JOBS are
// dropped and every result of that set carries excess_dropped.

module preemptive_priority_scheduler import pps_pkg::*; #(
   parameter int MAX_JOBS = MAX_JOBS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDX_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W   = $clog2(MAX_JOBS + 1);
   localparam int TIME_W  = $clog2(MAX_JOBS + 1) + BURST_W;
   localparam int ENTRY_W = $bits(job_entry_type);
   localparam int MEM_W   = ENTRY_W + TIME_W;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_APPLY,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_WAIT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] done_ff, done_in;
   logic             overflow_ff, overflow_in;
   logic [TIME_W-1:0] clock_ff, clock_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             eval_valid_ff, eval_valid_in;
   logic [IDX_W-1:0] eval_idx_ff, eval_idx_in;
   logic [BURST_W-1:0] span_ff, span_in;
   logic             preempt_ff, preempt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             req_accept;
   logic             scan_start;
   logic             scan_last;
   logic [BURST_W-1:0] burst_clamped;
   logic [TIME_W-1:0] gap;
   logic [TIME_W-1:0] finish_at;
   logic [TIME_W-1:0] rd_finish;
   logic [TIME_W-1:0] turnaround;
   logic [TIME_W-1:0] waiting;

   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [MEM_W-1:0]  mem_wr_data;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic [MEM_W-1:0]  mem_rd_data;
   job_entry_type     load_entry;
   job_entry_type     done_entry;
   job_entry_type     rd_entry;

   sel_status_type    sel_status;
   logic [IDX_W-1:0]  pick_idx;
   job_entry_type     pick_entry;

   pps_job_mem #(
      .DEPTH  (MAX_JOBS),
      .ADDR_W (IDX_W),
      .DATA_W (MEM_W)
   ) u_job_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pps_select #(
      .IDX_W  (IDX_W),
      .TIME_W (TIME_W)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .clear      (scan_start),
      .eval_valid (eval_valid_ff),
      .eval_idx   (eval_idx_ff),
      .entry      (rd_entry),
      .now        (clock_ff),
      .status     (sel_status),
      .pick_idx   (pick_idx),
      .pick_entry (pick_entry)
   );

   assign rd_entry  = job_entry_type'(mem_rd_data[MEM_W-1:TIME_W]);
   assign rd_finish = mem_rd_data[TIME_W-1:0];

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_LOAD);
   assign scan_last  = (CNT_W'(scan_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      burst_clamped = (req_data.burst_time == '0) ? BURST_W'(1) : req_data.burst_time;
      load_entry.arrival_time   = req_data.arrival_time;
      load_entry.burst_time     = burst_clamped;
      load_entry.job_priority   = req_data.job_priority;
      load_entry.remaining_time = burst_clamped;

      gap       = TIME_W'(sel_status.next_arrival) - clock_ff;
      finish_at = clock_ff + TIME_W'(span_ff);
      done_entry = pick_entry;
      done_entry.remaining_time = pick_entry.remaining_time - span_ff;

      turnaround = rd_finish - TIME_W'(rd_entry.arrival_time);
      waiting    = turnaround - TIME_W'(rd_entry.burst_time);
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      done_in       = done_ff;
      overflow_in   = overflow_ff;
      clock_in      = clock_ff;
      scan_in       = scan_ff;
      eval_valid_in = 1'b0;
      eval_idx_in   = scan_ff;
      span_in       = span_ff;
      preempt_in    = preempt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      scan_start    = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = count_ff[IDX_W-1:0];
      mem_wr_data   = {load_entry, TIME_W'(0)};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = scan_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (count_ff < CNT_W'(MAX_JOBS)) begin
                  mem_wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_data.last_item) begin
                  clock_in   = '0;
                  done_in    = '0;
                  scan_in    = '0;
                  scan_start = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            mem_rd_en     = 1'b1;
            eval_valid_in = 1'b1;
            if (scan_last) begin
               state_in = ST_SCAN_END;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         ST_SCAN_END: begin
            // The last row of the pass is being judged in this cycle.
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!sel_status.found) begin
               clock_in   = TIME_W'(sel_status.next_arrival);
               scan_in    = '0;
               scan_start = 1'b1;
               state_in   = ST_SCAN;
            end else begin
               preempt_in = sel_status.pending &&
                            (gap < TIME_W'(pick_entry.remaining_time));
               span_in    = preempt_in ? gap[BURST_W-1:0] : pick_entry.remaining_time;
               state_in   = ST_APPLY;
            end
         end
         ST_APPLY: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pick_idx;
            mem_wr_data = {done_entry, finish_at};
            clock_in    = finish_at;
            scan_in     = '0;
            if (!preempt_ff && ((done_ff + CNT_W'(1)) == count_ff)) begin
               state_in = ST_OUT_RD;
            end else begin
               if (!preempt_ff) begin
                  done_in = done_ff + CNT_W'(1);
               end
               scan_start = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_OUT_RD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rsp_valid_in                = 1'b1;
            rsp_data_in.job_index       = RSP_INDEX_W'(scan_ff);
            rsp_data_in.finish_time     = RSP_TIME_W'(rd_finish);
            rsp_data_in.turnaround_time = RSP_TIME_W'(turnaround);
            rsp_data_in.waiting_time    = RSP_TIME_W'(waiting);
            rsp_data_in.excess_dropped  = overflow_ff;
            rsp_data_in.last_result     = scan_last;
            state_in                    = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (scan_last) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  clock_in    = '0;
                  state_in    = ST_LOAD;
               end else begin
                  scan_in  = scan_ff + IDX_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         done_ff       <= '0;
         overflow_ff   <= 1'b0;
         clock_ff      <= '0;
         scan_ff       <= '0;
         eval_valid_ff <= 1'b0;
         preempt_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         done_ff       <= done_in;
         overflow_ff   <= overflow_in;
         clock_ff      <= clock_in;
         scan_ff       <= scan_in;
         eval_valid_ff <= eval_valid_in;
         preempt_ff    <= preempt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      eval_idx_ff <= eval_idx_in;
      span_ff     <= span_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/pps_job_mem.sv
`default_nettype none

module pps_job_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 77
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/pps_select.sv
`default_nettype none

module pps_select import pps_pkg::*; #(
   parameter int IDX_W  = 4,
   parameter int TIME_W = 21
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear,
   input  wire logic             eval_valid,
   input  wire logic [IDX_W-1:0] eval_idx,
   input  wire job_entry_type    entry,
   input  wire logic [TIME_W-1:0] now,
   output sel_status_type        status,
   output logic      [IDX_W-1:0] pick_idx,
   output job_entry_type         pick_entry
);

   logic                 found_ff, found_in;
   logic                 pending_ff, pending_in;
   logic [ARRIVAL_W-1:0] next_arrival_ff, next_arrival_in;
   logic [IDX_W-1:0]     pick_idx_ff, pick_idx_in;
   job_entry_type        pick_entry_ff, pick_entry_in;
   logic                 live;
   logic                 arrived;

   always_comb begin
      live            = eval_valid && (entry.remaining_time != '0);
      arrived         = TIME_W'(entry.arrival_time) <= now;
      found_in        = found_ff;
      pending_in      = pending_ff;
      next_arrival_in = next_arrival_ff;
      pick_idx_in     = pick_idx_ff;
      pick_entry_in   = pick_entry_ff;
      if (clear) begin
         found_in   = 1'b0;
         pending_in = 1'b0;
      end else if (live && arrived) begin
         // Strict compare keeps the lowest index on a priority tie.
         if (!found_ff || (entry.job_priority < pick_entry_ff.job_priority)) begin
            found_in      = 1'b1;
            pick_idx_in   = eval_idx;
            pick_entry_in = entry;
         end
      end else if (live) begin
         if (!pending_ff || (entry.arrival_time < next_arrival_ff)) begin
            pending_in      = 1'b1;
            next_arrival_in = entry.arrival_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff   <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         found_ff   <= found_in;
         pending_ff <= pending_in;
      end
      next_arrival_ff <= next_arrival_in;
      pick_idx_ff     <= pick_idx_in;
      pick_entry_ff   <= pick_entry_in;
   end

   assign status.found        = found_ff;
   assign status.pending      = pending_ff;
   assign status.next_arrival = next_arrival_ff;
   assign pick_idx            = pick_idx_ff;
   assign pick_entry          = pick_entry_ff;

endmodule

`default_nettype wire

>>> hw/rtl/pps_checker.sv
`default_nettype none

module pps_checker import pps_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // No new job may load while results of the previous set are out.
   a_no_load_during_results: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall
   ) else $error("request taken while a result is pending");

   // Closing a set starts the run, so input must stall right after.
   a_stall_after_last: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.last_item) |=> req_stall
   ) else $error("input not stalled after the last request of a set");

   // Taking the final result of a set reopens the input.
   a_reopen_after_last: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_result) |=> (!req_stall && !rsp_valid)
   ) else $error("input not reopened after the last result");

   a_rsp_hold: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data))
   ) else $error("stalled result changed or dropped");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

`default_nettype wire

>>> verif/tb_preemptive_priority_scheduler.sv
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler import pps_pkg::*; ();

   localparam int JOB_SLOTS = MAX_JOBS_DEFAULT;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef enum int {
      MIX_DENSE,
      MIX_SPREAD,
      MIX_FULL_RANGE,
      MIX_WIDE_PRIORITY
   } mix_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predicted job table of the set being loaded.
   int unsigned job_arrival [JOB_SLOTS];
   int unsigned job_burst [JOB_SLOTS];
   int unsigned job_priority [JOB_SLOTS];
   int unsigned job_left [JOB_SLOTS];
   int unsigned job_finish [JOB_SLOTS];
   int unsigned loaded_jobs = 0;
   bit          set_overflow = 1'b0;

   rsp_type expected_results[$];

   int requests_seen = 0;
   int sets_seen = 0;
   int overflow_sets = 0;
   int results_checked = 0;
   int failures = 0;

   bit   idle_on = 1'b1;
   bit   long_hold = 1'b0;
   int   stall_left = 0;
   event start_long_hold;

   preemptive_priority_scheduler #(.MAX_JOBS(JOB_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Event-driven schedule: run the best ready job until it ends or the next
   // job arrives, or jump an idle span straight to the next arrival.
   function automatic void schedule_set();
      int unsigned now;
      int unsigned finished;
      int unsigned pick;
      int unsigned next_arr;
      int unsigned span;
      bit          found;
      bit          pending;
      now = 0;
      finished = 0;
      while (finished < loaded_jobs) begin
         found = 1'b0;
         pending = 1'b0;
         pick = 0;
         next_arr = 0;
         for (int i = 0; i < loaded_jobs; i++) begin
            if (job_left[i] == 0) continue;
            if (job_arrival[i] <= now) begin
               if (!found || job_priority[i] < job_priority[pick]) begin
                  pick = i;
                  found = 1'b1;
               end
            end else if (!pending || job_arrival[i] < next_arr) begin
               next_arr = job_arrival[i];
               pending = 1'b1;
            end
         end
         if (!found) begin
            now = next_arr;
         end else begin
            span = job_left[pick];
            if (pending && next_arr - now < span) span = next_arr - now;
            job_left[pick] -= span;
            now += span;
            if (job_left[pick] == 0) begin
               job_finish[pick] = now;
               finished++;
            end
         end
      end
   endfunction

   function automatic void predict_request(req_type r);
      rsp_type     want;
      int unsigned burst;
      int unsigned turnaround;
      int unsigned waiting;
      burst = (r.burst_time == 0) ? 1 : 32'(r.burst_time);
      requests_seen++;
      if (loaded_jobs < JOB_SLOTS) begin
         job_arrival[loaded_jobs] = 32'(r.arrival_time);
         job_burst[loaded_jobs] = burst;
         job_priority[loaded_jobs] = 32'(r.job_priority);
         job_left[loaded_jobs] = burst;
         loaded_jobs++;
      end else begin
         set_overflow = 1'b1;
      end
      if (r.last_item) begin
         schedule_set();
         for (int k = 0; k < loaded_jobs; k++) begin
            turnaround = job_finish[k] - job_arrival[k];
            waiting = turnaround - job_burst[k];
            want.job_index = k[RSP_INDEX_W-1:0];
            want.finish_time = job_finish[k][RSP_TIME_W-1:0];
            want.turnaround_time = turnaround[RSP_TIME_W-1:0];
            want.waiting_time = waiting[RSP_TIME_W-1:0];
            want.excess_dropped = set_overflow;
            want.last_result = (k + 1 == loaded_jobs);
            expected_results.push_back(want);
         end
         sets_seen++;
         if (set_overflow) overflow_sets++;
         loaded_jobs = 0;
         set_overflow = 1'b0;
      end
   endfunction

   function automatic void check_result(rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected result for job %0d", got.job_index);
         failures++;
         return;
      end
      want = expected_results.pop_front();
      results_checked++;
      if (got.job_index !== want.job_index) begin
         $error("job_index: expected %0d, actual %0d", want.job_index, got.job_index);
         failures++;
      end
      if (got.finish_time !== want.finish_time) begin
         $error("finish_time: expected %0d, actual %0d", want.finish_time, got.finish_time);
         failures++;
      end
      if (got.turnaround_time !== want.turnaround_time) begin
         $error("turnaround_time: expected %0d, actual %0d",
                want.turnaround_time, got.turnaround_time);
         failures++;
      end
      if (got.waiting_time !== want.waiting_time) begin
         $error("waiting_time: expected %0d, actual %0d",
                want.waiting_time, got.waiting_time);
         failures++;
      end
      if (got.excess_dropped !== want.excess_dropped) begin
         $error("excess_dropped: expected %0d, actual %0d",
                want.excess_dropped, got.excess_dropped);
         failures++;
      end
      if (got.last_result !== want.last_result) begin
         $error("last_result: expected %0d, actual %0d", want.last_result, got.last_result);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) predict_request(req_data);
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
   end

   // Output stall: short random bursts, or one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial forever begin
      @(start_long_hold);
      @(negedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(negedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_job(input int unsigned arrival, input int unsigned burst,
                           input int unsigned prio, input bit last);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data.arrival_time <= arrival[ARRIVAL_W-1:0];
      req_data.burst_time <= burst[BURST_W-1:0];
      req_data.job_priority <= prio[PRIORITY_W-1:0];
      req_data.last_item <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_set_size();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll <= 5) return $urandom_range(1, 6);
      if (roll <= 7) return $urandom_range(7, JOB_SLOTS);
      if (roll == 8) return JOB_SLOTS;
      return $urandom_range(JOB_SLOTS + 1, JOB_SLOTS + 4);
   endfunction

   task automatic send_random_set(input int jobs);
      mix_type     mix;
      int unsigned arrival;
      int unsigned burst;
      int unsigned prio;
      mix = mix_type'($urandom_range(0, 3));
      for (int j = 0; j < jobs; j++) begin
         case (mix)
            MIX_DENSE: begin
               arrival = $urandom_range(0, 15);
               burst = $urandom_range(1, 8);
               prio = $urandom_range(0, 3);
            end
            MIX_SPREAD: begin
               arrival = $urandom_range(0, 300);
               burst = $urandom_range(1, 60);
               prio = $urandom_range(0, 15);
            end
            MIX_FULL_RANGE: begin
               arrival = $urandom_range(0, 65535);
               burst = $urandom_range(0, 65535);
               prio = $urandom_range(0, 255);
            end
            default: begin
               arrival = $urandom_range(0, 40);
               burst = $urandom_range(1, 20);
               prio = $urandom_range(0, 255);
            end
         endcase
         if ($urandom_range(0, 15) == 0) burst = 0;
         send_job(arrival, burst, prio, j == jobs - 1);
      end
   endtask

   // A zero burst is served for one tick.
   task automatic test_single_job();
      send_job(0, 0, 0, 1'b1);
      wait_results_drained();
   endtask

   // Late high-priority jobs preempt; equal priorities go to the lower index.
   task automatic test_preemption_and_ties();
      send_job(0, 10, 5, 1'b0);
      send_job(3, 2, 1, 1'b0);
      send_job(3, 4, 1, 1'b0);
      send_job(5, 1, 0, 1'b1);
      wait_results_drained();
   endtask

   // Field extremes, with long idle spans between arrivals.
   task automatic test_field_extremes();
      send_job(65535, 65535, 255, 1'b0);
      send_job(0, 1, 0, 1'b0);
      send_job(40000, 2, 128, 1'b1);
      wait_results_drained();
   endtask

   // A full table plus one dropped job that still closes the set.
   task automatic test_capacity_overflow();
      for (int j = 0; j <= JOB_SLOTS; j++)
         send_job($urandom_range(0, 50), $urandom_range(1, 12), $urandom_range(0, 7),
                  j == JOB_SLOTS);
      wait_results_drained();
   endtask

   // Results are held off for a long time while further sets are offered.
   task automatic test_output_hold_off();
      -> start_long_hold;
      for (int s = 0; s < 3; s++) send_random_set(5);
      wait_results_drained();
   endtask

   task automatic test_random_sets(input int item_target);
      int start_count;
      start_count = requests_seen;
      while (requests_seen - start_count < item_target) begin
         send_random_set(pick_set_size());
         if ($urandom_range(0, 5) == 0) wait_results_drained();
      end
      wait_results_drained();
   endtask

   initial begin
      int waited;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_job();
      test_preemption_and_ties();
      test_field_extremes();
      test_capacity_overflow();
      test_output_hold_off();
      test_random_sets(260);
      idle_on = 1'b0;
      test_random_sets(60);

      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (expected_results.size() != 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         failures++;
      end
      $display("Scheduled %0d job sets from %0d requests (%0d with dropped jobs).",
               sets_seen, requests_seen, overflow_sets);
      $display("Compared %0d results, %0d mismatches.", results_checked, failures);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/pps_pkg.sv
hw/rtl/pps_job_mem.sv
hw/rtl/pps_select.sv
hw/rtl/preemptive_priority_scheduler.sv
hw/rtl/pps_checker.sv
verif/tb_preemptive_priority_scheduler.sv
